// ----- rtl/pida_pkg.sv -----
// Shared constants and codes for the positional insert/delete array.
// No dependencies; imported by the top level and by the checker.
package pida_pkg;

  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int OPC_W  = 3;
  localparam int STS_W  = 2;
  localparam int OCNT_W = 8;

  // stream payload layout, lowest field first
  localparam int S_BITS = OPC_W + POS_W + DATA_W;
  localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8;
  localparam int M_BITS = STS_W + DATA_W + OCNT_W;
  localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

// ----- rtl/pida_ram.sv -----
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module pida_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/positional_insert_delete_array.sv -----
// Top level of the positional insert/delete array.
// Depends on pida_pkg and pida_ram.
//
// Usage:
//   Requests arrive on the s_* stream: op (clear, insert, update, delete,
//   read), position and value. Every request gives exactly one result on the
//   m_* stream: status, read value (zero unless a successful read) and the
//   fill count after the operation.
//   Entries live in one RAM with a registered read; the fill count is a
//   register. Insert and delete move entries one per cycle through the RAM
//   (read one entry, write it to its neighbor while reading the next).
//   Clear, update, refused or unknown op, insert at the end and delete of
//   the last entry are answered straight from the idle state. A read waits
//   for the registered RAM data. Insert at p below count n moves entries
//   n - 1 down to p one place up, then writes the value at p; delete at p
//   below n - 1 moves entries p + 1 up to n - 1 one place down.
//   One request is in work at a time; s_tready is high when the block is
//   idle and the result register is empty or being drained in that cycle.
//   A stalled receiver holds the result; new requests wait behind it.
//   Reset empties the array (count zero) and drops any pending result; no
//   clearing pass is needed.
module positional_insert_delete_array (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // op [2:0], position [10:3], value [42:11], zero fill above
  input  logic [pida_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status [1:0], read_value [33:2], count [41:34], zero fill above
  output logic [pida_pkg::M_TDATA_W-1:0]  m_tdata
);
  import pida_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT_UP,
    S_INS_LAST,
    S_SHIFT_DN
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [ADDR_W-1:0]   pos, pos_next;
  logic [ADDR_W-1:0]   addr, addr_next;
  logic [DATA_W-1:0]   value, value_next;
  logic                out_valid_next;
  logic [STS_W-1:0]    out_status, out_status_next;
  logic [DATA_W-1:0]   out_rdata, out_rdata_next;
  logic [CNT_W-1:0]    out_cnt, out_cnt_next;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  logic [OPC_W-1:0]    in_op;
  logic [POS_W-1:0]    in_pos;
  logic [DATA_W-1:0]   in_value;
  logic [CMP_W-1:0]    pos_ext, cnt_ext;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CMP_W-1:0]    out_cnt_ext;
  logic                accept;

  assign in_op    = s_tdata[OPC_W-1:0];
  assign in_pos   = s_tdata[OPC_W+POS_W-1:OPC_W];
  assign in_value = s_tdata[OPC_W+POS_W+DATA_W-1:OPC_W+POS_W];
  assign pos_ext  = CMP_W'(in_pos);
  assign cnt_ext  = CMP_W'(cnt);
  assign cnt_m1   = cnt - CNT_W'(1);

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  pida_ram #(
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pos_next        = pos;
    addr_next       = addr;
    value_next      = value;
    out_valid_next  = m_tvalid && !m_tready;
    out_status_next = out_status;
    out_rdata_next  = out_rdata;
    out_cnt_next    = out_cnt;
    mem_we          = 1'b0;
    mem_waddr       = addr;
    mem_wdata       = mem_rdata;
    mem_raddr       = addr;

    case (state)
      S_IDLE: begin
        if (accept) begin
          out_valid_next  = 1'b1;
          out_status_next = ST_OK;
          out_rdata_next  = '0;
          out_cnt_next    = cnt;
          pos_next        = in_pos[ADDR_W-1:0];
          value_next      = in_value;
          case (in_op)
            OP_CLEAR: begin
              cnt_next     = '0;
              out_cnt_next = '0;
            end
            OP_INSERT: begin
              if (cnt == CNT_W'(DEPTH)) begin
                out_status_next = ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                out_status_next = ST_RANGE;
              end else if (pos_ext == cnt_ext) begin
                mem_we       = 1'b1;
                mem_waddr    = in_pos[ADDR_W-1:0];
                mem_wdata    = in_value;
                cnt_next     = cnt + CNT_W'(1);
                out_cnt_next = cnt + CNT_W'(1);
              end else begin
                // move entries up, starting from the top one
                out_valid_next = 1'b0;
                mem_raddr      = cnt_m1[ADDR_W-1:0];
                addr_next      = cnt_m1[ADDR_W-1:0];
                state_next     = S_SHIFT_UP;
              end
            end
            OP_UPDATE, OP_DELETE, OP_READ: begin
              if (cnt == '0) begin
                out_status_next = ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                out_status_next = ST_RANGE;
              end else if (in_op == OP_UPDATE) begin
                mem_we    = 1'b1;
                mem_waddr = in_pos[ADDR_W-1:0];
                mem_wdata = in_value;
              end else if (in_op == OP_DELETE) begin
                if (pos_ext == CMP_W'(cnt_m1)) begin
                  cnt_next     = cnt_m1;
                  out_cnt_next = cnt_m1;
                end else begin
                  out_valid_next = 1'b0;
                  mem_raddr      = in_pos[ADDR_W-1:0] + ADDR_W'(1);
                  addr_next      = in_pos[ADDR_W-1:0] + ADDR_W'(1);
                  state_next     = S_SHIFT_DN;
                end
              end else begin
                out_valid_next = 1'b0;
                mem_raddr      = in_pos[ADDR_W-1:0];
                state_next     = S_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_WAIT: begin
        out_valid_next = 1'b1;
        out_rdata_next = mem_rdata;
        state_next     = S_IDLE;
      end
      S_SHIFT_UP: begin
        // rdata holds entry addr; it goes one place up
        mem_we    = 1'b1;
        mem_waddr = addr + ADDR_W'(1);
        if (addr == pos) begin
          state_next = S_INS_LAST;
        end else begin
          mem_raddr = addr - ADDR_W'(1);
          addr_next = addr - ADDR_W'(1);
        end
      end
      S_INS_LAST: begin
        mem_we         = 1'b1;
        mem_waddr      = pos;
        mem_wdata      = value;
        cnt_next       = cnt + CNT_W'(1);
        out_valid_next = 1'b1;
        out_cnt_next   = cnt + CNT_W'(1);
        state_next     = S_IDLE;
      end
      S_SHIFT_DN: begin
        // rdata holds entry addr; it goes one place down
        mem_we    = 1'b1;
        mem_waddr = addr - ADDR_W'(1);
        if (addr == cnt_m1[ADDR_W-1:0]) begin
          cnt_next       = cnt_m1;
          out_valid_next = 1'b1;
          out_cnt_next   = cnt_m1;
          state_next     = S_IDLE;
        end else begin
          mem_raddr = addr + ADDR_W'(1);
          addr_next = addr + ADDR_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= out_valid_next;
    end
    pos        <= pos_next;
    addr       <= addr_next;
    value      <= value_next;
    out_status <= out_status_next;
    out_rdata  <= out_rdata_next;
    out_cnt    <= out_cnt_next;
  end

  assign out_cnt_ext = CMP_W'(out_cnt);
  assign m_tdata = M_TDATA_W'({out_cnt_ext[OCNT_W-1:0], out_rdata, out_status});

endmodule

// ----- rtl/pida_check.sv -----
// Port-level checker for the positional insert/delete array, with its bind.
// Depends on pida_pkg; attaches to positional_insert_delete_array.
module pida_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [pida_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pida_pkg::M_TDATA_W-1:0] m_tdata
);
  import pida_pkg::*;

  localparam int RV_LO = STS_W;
  localparam int CT_LO = STS_W + DATA_W;

  // reset drops any pending result
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[CT_LO+OCNT_W-1:CT_LO] <= OCNT_W'(DEPTH))
    else $error("count above depth");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[STS_W-1:0] != ST_OK |-> m_tdata[RV_LO+DATA_W-1:RV_LO] == '0)
    else $error("refused request carries read data");

  // clear answers in the next cycle with an empty array
  a_clear: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[OPC_W-1:0] == OP_CLEAR |=>
      m_tvalid && m_tdata[STS_W-1:0] == ST_OK
      && m_tdata[CT_LO+OCNT_W-1:CT_LO] == '0)
    else $error("clear result wrong");

endmodule

bind positional_insert_delete_array pida_check u_pida_check (.*);
